// ----- design/ifrw_pkg.sv -----
// Shared types and constants for the indexed frame to RGBA writer.
package ifrw_pkg;

    localparam int MAX_SIDE_DEF     = 1024;
    localparam int PALETTE_SIZE_DEF = 256;

    localparam int COORD_W   = 10;
    localparam int SIDE_W    = 11;
    localparam int PITCH_W   = 4;
    localparam int TRANSP_W  = 9;
    localparam int INDEX_W   = 8;
    localparam int RGB_W     = 24;
    localparam int RGBA_W    = 32;
    localparam int ADDR_W    = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_LEFT        = 3'd0,
        REG_FRAME_TOP         = 3'd1,
        REG_FRAME_WIDTH       = 3'd2,
        REG_FRAME_HEIGHT      = 3'd3,
        REG_SCREEN_HEIGHT     = 3'd4,
        REG_PITCH_LOG2        = 3'd5,
        REG_ROTATE_RIGHT      = 3'd6,
        REG_TRANSPARENT_INDEX = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [COORD_W-1:0]  frame_left;
        logic [COORD_W-1:0]  frame_top;
        logic [SIDE_W-1:0]   frame_width;
        logic [SIDE_W-1:0]   frame_height;
        logic [SIDE_W-1:0]   screen_height;
        logic [PITCH_W-1:0]  pitch_log2;
        logic                rotate_right;
        logic [TRANSP_W-1:0] transparent_index;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              done;
    } t_pix_pos;

endpackage

// ----- design/indexed_frame_to_rgba_writer_unit.sv -----
// Top level of the indexed frame to RGBA writer: config, palette RAM and output stage.
//
// Usage: requests arrive on the input channel (i_in_valid / o_in_ready). A request
// with i_mode = 0 writes i_palette_rgb into palette entry i_color_index; a request
// with i_mode = 1 carries one pixel index of the image rectangle in raster order.
// Every request yields exactly one result on the output channel (o_out_valid /
// i_out_ready): frame buffer word address, RGBA (alpha 0xff when written, zero
// otherwise), write enable (low for palette writes and for the transparent
// index) and frame done on the last pixel of the rectangle.
// The palette is read from a synchronous RAM at the edge that accepts the pixel,
// and the result register holds it until taken.
// Throughput is one request per cycle while the receiver takes results; a
// palette write followed at once by a pixel reading the same entry sees the new value.
// When the receiver stalls, the result register holds and o_in_ready stays high
// only while that register is empty or being drained in the same cycle.
// Reset clears the row and column counters and sets all config registers to
// their defaults; palette contents are undefined until written. Config writes
// on i_cfg_we take effect at once and are meant to come while the block is idle.
module indexed_frame_to_rgba_writer_unit #(
    parameter int MAX_SIDE     = ifrw_pkg::MAX_SIDE_DEF,
    parameter int PALETTE_SIZE = ifrw_pkg::PALETTE_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ifrw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ifrw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [ifrw_pkg::INDEX_W-1:0]        i_color_index,
    input  logic [ifrw_pkg::RGB_W-1:0]          i_palette_rgb,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_write_enable,
    output logic [ifrw_pkg::ADDR_W-1:0]         o_pixel_address,
    output logic [ifrw_pkg::RGBA_W-1:0]         o_rgba,
    output logic                                o_frame_done
);
    import ifrw_pkg::*;

    localparam int PAL_AW = $clog2(PALETTE_SIZE);

    t_cfg              r_cfg;
    t_pix_pos          w_pos;
    logic              w_accept;
    logic              w_pixel_step;
    logic              w_in_range;
    logic              w_skip;
    logic              w_ram_we;
    logic              w_ram_re;
    logic [RGB_W-1:0]  w_rdata;

    logic              r_valid;
    logic              r_pixel;
    logic              r_we;
    logic              r_use_ram;
    logic [ADDR_W-1:0] r_addr;
    logic              r_done;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_left        <= '0;
            r_cfg.frame_top         <= '0;
            r_cfg.frame_width       <= SIDE_W'(1);
            r_cfg.frame_height      <= SIDE_W'(1);
            r_cfg.screen_height     <= SIDE_W'(1);
            r_cfg.pitch_log2        <= PITCH_W'(10);
            r_cfg.rotate_right      <= 1'b0;
            r_cfg.transparent_index <= TRANSP_W'(256);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_LEFT:        r_cfg.frame_left    <= i_cfg_data[COORD_W-1:0];
                REG_FRAME_TOP:         r_cfg.frame_top     <= i_cfg_data[COORD_W-1:0];
                REG_FRAME_WIDTH:       r_cfg.frame_width   <= i_cfg_data[SIDE_W-1:0];
                REG_FRAME_HEIGHT:      r_cfg.frame_height  <= i_cfg_data[SIDE_W-1:0];
                REG_SCREEN_HEIGHT:     r_cfg.screen_height <= i_cfg_data[SIDE_W-1:0];
                REG_PITCH_LOG2:        r_cfg.pitch_log2    <= i_cfg_data[PITCH_W-1:0];
                REG_ROTATE_RIGHT:      r_cfg.rotate_right  <= i_cfg_data[0];
                REG_TRANSPARENT_INDEX: r_cfg.transparent_index <= i_cfg_data[TRANSP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready   = !r_valid || i_out_ready;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_pixel_step = w_accept && i_mode;
    assign w_in_range   = ({1'b0, i_color_index} < 9'(PALETTE_SIZE));
    // Index 256 and above in the key register disables transparency.
    assign w_skip       = !r_cfg.transparent_index[TRANSP_W-1]
                          && (r_cfg.transparent_index[INDEX_W-1:0] == i_color_index);
    assign w_ram_we     = w_accept && !i_mode && w_in_range;
    assign w_ram_re     = w_pixel_step && w_in_range && !w_skip;

    ifrw_addr_gen #(
        .MAX_SIDE (MAX_SIDE)
    ) u_addr_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (w_pixel_step),
        .o_pos   (w_pos)
    );

    ifrw_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_SIZE)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_color_index[PAL_AW-1:0]),
        .i_wdata (i_palette_rgb),
        .i_re    (w_ram_re),
        .i_raddr (i_color_index[PAL_AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Output stage: valid needs reset, payload does not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pixel   <= i_mode;
            r_we      <= i_mode && !w_skip;
            r_use_ram <= w_ram_re;
            r_addr    <= i_mode ? w_pos.addr : '0;
            r_done    <= i_mode && w_pos.done;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_write_enable  = r_we;
    assign o_pixel_address = r_addr;
    assign o_frame_done    = r_done;
    always_comb begin
        if (r_use_ram) begin
            o_rgba = {w_rdata, ALPHA_OPAQUE};
        end else if (r_we) begin
            o_rgba = {RGB_W'(0), ALPHA_OPAQUE};
        end else begin
            o_rgba = '0;
        end
    end

    a_we_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_enable |-> o_rgba[7:0] == ALPHA_OPAQUE)
        else $error("written pixel without opaque alpha");

    a_palette_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_pixel |->
            !o_write_enable && !o_frame_done && o_pixel_address == '0 && o_rgba == '0)
        else $error("palette write result not all zero");

    a_read_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_re |=> o_out_valid && r_use_ram && o_write_enable)
        else $error("palette read without a pending pixel result");
endmodule

// ----- design/ifrw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ifrw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/ifrw_addr_gen.sv -----
// Raster counters and frame buffer address generation, with optional quarter turn.
module ifrw_addr_gen #(
    parameter int MAX_SIDE = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ifrw_pkg::t_cfg    i_cfg,
    input  logic              i_step,
    output ifrw_pkg::t_pix_pos o_pos
);
    import ifrw_pkg::*;

    localparam int CNT_W = $clog2(MAX_SIDE);
    localparam int CMP_W = (CNT_W + 1 > SIDE_W + 1) ? CNT_W + 1 : SIDE_W + 1;

    logic [CNT_W-1:0]  r_col, n_col;
    logic [CNT_W-1:0]  r_row, n_row;
    logic [CMP_W-1:0]  w_width, w_height;
    logic [CMP_W-1:0]  w_col_inc, w_row_inc;
    logic              w_last_col, w_last_row;
    logic [ADDR_W-1:0] w_left_col, w_top_row, w_rot_col;
    logic [ADDR_W-1:0] w_row_addr, w_col_addr;

    // A zero side acts as one, anything above the maximum as the maximum.
    always_comb begin
        if (i_cfg.frame_width == '0) begin
            w_width = CMP_W'(1);
        end else if (CMP_W'(i_cfg.frame_width) > CMP_W'(MAX_SIDE)) begin
            w_width = CMP_W'(MAX_SIDE);
        end else begin
            w_width = CMP_W'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height == '0) begin
            w_height = CMP_W'(1);
        end else if (CMP_W'(i_cfg.frame_height) > CMP_W'(MAX_SIDE)) begin
            w_height = CMP_W'(MAX_SIDE);
        end else begin
            w_height = CMP_W'(i_cfg.frame_height);
        end
    end

    assign w_col_inc  = CMP_W'(r_col) + CMP_W'(1);
    assign w_row_inc  = CMP_W'(r_row) + CMP_W'(1);
    assign w_last_col = (w_col_inc >= w_width);
    assign w_last_row = (w_row_inc >= w_height);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (w_last_col) begin
                n_col = '0;
                n_row = w_last_row ? '0 : w_row_inc[CNT_W-1:0];
            end else begin
                n_col = w_col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign w_left_col = ADDR_W'(i_cfg.frame_left) + ADDR_W'(r_col);
    assign w_top_row  = ADDR_W'(i_cfg.frame_top) + ADDR_W'(r_row);
    assign w_rot_col  = ADDR_W'(i_cfg.screen_height) - ADDR_W'(i_cfg.frame_top)
                        - ADDR_W'(1) - ADDR_W'(r_row);

    // Rotated: column counter picks the row, row counter counts back from the bottom.
    assign w_row_addr = i_cfg.rotate_right ? w_left_col : w_top_row;
    assign w_col_addr = i_cfg.rotate_right ? w_rot_col : w_left_col;

    assign o_pos.addr = (w_row_addr << i_cfg.pitch_log2) + w_col_addr;
    assign o_pos.done = w_last_col && w_last_row;
endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the indexed frame to RGBA writer: directed rows, then random frames.
module tb_top;
    import ifrw_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 175;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [RGBA_W-1:0] rgba;
        logic              done;
    } t_fb_write;

    typedef enum logic [1:0] {ROW_PALETTE, ROW_PIXEL, ROW_CONFIG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_cfg_reg              cfg_sel;
        logic [CFG_DATA_W-1:0] value;
        logic [INDEX_W-1:0]    index;
        logic [RGB_W-1:0]      rgb;
        logic                  typed;
        t_fb_write             result;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_mode = 1'b0;
    logic [INDEX_W-1:0]    i_color_index = '0;
    logic [RGB_W-1:0]      i_palette_rgb = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_write_enable;
    logic [ADDR_W-1:0]     o_pixel_address;
    logic [RGBA_W-1:0]     o_rgba;
    logic                  o_frame_done;

    // Shadow state of the block
    t_cfg               cfg_shadow;
    logic [RGB_W-1:0]   palette_shadow [PALETTE_SIZE_DEF];
    bit                 palette_written [PALETTE_SIZE_DEF];
    logic [INDEX_W-1:0] written_indices [$];
    logic [9:0]         row_count;
    logic [9:0]         column_count;

    t_fb_write fb_write_q [$];
    int        fail_count = 0;
    int        idle_cycles = 0;
    bit        steady_run = 1'b0;

    indexed_frame_to_rgba_writer_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_color_index   (i_color_index),
        .i_palette_rgb   (i_palette_rgb),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_write_enable  (o_write_enable),
        .o_pixel_address (o_pixel_address),
        .o_rgba          (o_rgba),
        .o_frame_done    (o_frame_done)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [SIDE_W-1:0] effective_side(logic [SIDE_W-1:0] v);
        if (v == '0) begin
            return 11'd1;
        end
        if (v > SIDE_W'(MAX_SIDE_DEF)) begin
            return SIDE_W'(MAX_SIDE_DEF);
        end
        return v;
    endfunction

    // Compute the frame buffer write for one request; a pixel also advances the raster counters.
    task automatic predict_fb_write(input logic mode, input logic [INDEX_W-1:0] idx,
                                    input logic [RGB_W-1:0] rgb, output t_fb_write res);
        logic [SIDE_W-1:0] width;
        logic [SIDE_W-1:0] height;
        logic [ADDR_W-1:0] row;
        logic [ADDR_W-1:0] col;
        logic              skip;
        logic              last_col;
        logic              last_row;
        res = '0;
        if (mode == 1'b0) begin
            if (!palette_written[idx]) begin
                written_indices.push_back(idx);
            end
            palette_shadow[idx]  = rgb;
            palette_written[idx] = 1'b1;
            return;
        end
        width  = effective_side(cfg_shadow.frame_width);
        height = effective_side(cfg_shadow.frame_height);
        if (cfg_shadow.rotate_right) begin
            row = ADDR_W'(cfg_shadow.frame_left) + ADDR_W'(column_count);
            col = ADDR_W'(cfg_shadow.screen_height) - ADDR_W'(cfg_shadow.frame_top)
                  - 20'd1 - ADDR_W'(row_count);
        end else begin
            row = ADDR_W'(cfg_shadow.frame_top) + ADDR_W'(row_count);
            col = ADDR_W'(cfg_shadow.frame_left) + ADDR_W'(column_count);
        end
        res.addr = (row << cfg_shadow.pitch_log2) + col;
        skip = !cfg_shadow.transparent_index[8]
               && (cfg_shadow.transparent_index[7:0] == idx);
        last_col = ({1'b0, column_count} + 11'd1) >= width;
        last_row = ({1'b0, row_count} + 11'd1) >= height;
        res.done = last_col && last_row;
        res.we   = !skip;
        res.rgba = skip ? '0 : {palette_shadow[idx], ALPHA_OPAQUE};
        if (last_col) begin
            column_count = '0;
            row_count    = last_row ? 10'd0 : row_count + 10'd1;
        end else begin
            column_count = column_count + 10'd1;
        end
    endtask

    // Present one request, hold it until taken, then record what it should produce.
    task automatic issue_request(input logic mode, input logic [INDEX_W-1:0] idx,
                                 input logic [RGB_W-1:0] rgb, input logic typed,
                                 input t_fb_write typed_res);
        int        gap;
        t_fb_write res;
        gap = steady_run ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_color_index <= idx;
        i_palette_rgb <= rgb;
        do @(posedge i_clk); while (!o_in_ready);
        predict_fb_write(mode, idx, rgb, res);
        fb_write_q.push_back(typed ? typed_res : res);
    endtask

    // Drop valid and let every outstanding result drain.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (fb_write_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg sel, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (sel)
            REG_FRAME_LEFT:        cfg_shadow.frame_left        = value[COORD_W-1:0];
            REG_FRAME_TOP:         cfg_shadow.frame_top         = value[COORD_W-1:0];
            REG_FRAME_WIDTH:       cfg_shadow.frame_width       = value;
            REG_FRAME_HEIGHT:      cfg_shadow.frame_height      = value;
            REG_SCREEN_HEIGHT:     cfg_shadow.screen_height     = value;
            REG_PITCH_LOG2:        cfg_shadow.pitch_log2        = value[PITCH_W-1:0];
            REG_ROTATE_RIGHT:      cfg_shadow.rotate_right      = value[0];
            REG_TRANSPARENT_INDEX: cfg_shadow.transparent_index = value[TRANSP_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_side();
        case ($urandom_range(0, 9))
            0: return 11'd0;
            1: return 11'($urandom_range(1025, 2047));
            2: return 11'd1024;
            default: return 11'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_coord();
        case ($urandom_range(0, 3))
            0: return 11'd0;
            1: return 11'd1023;
            default: return 11'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_reg_value(t_cfg_reg sel);
        case (sel)
            REG_FRAME_LEFT, REG_FRAME_TOP:      return random_coord();
            REG_FRAME_WIDTH, REG_FRAME_HEIGHT:  return random_side();
            REG_SCREEN_HEIGHT:                  return 11'($urandom_range(0, 2047));
            REG_PITCH_LOG2:                     return 11'($urandom_range(0, 15));
            REG_ROTATE_RIGHT:                   return 11'($urandom_range(0, 1));
            REG_TRANSPARENT_INDEX: begin
                case ($urandom_range(0, 3))
                    0: return 11'($urandom_range(256, 511));
                    default: begin
                        return 11'(written_indices[$urandom_range(0,
                                   written_indices.size() - 1)]);
                    end
                endcase
            end
            default: return '0;
        endcase
    endfunction

    task automatic issue_random_request();
        logic [INDEX_W-1:0] idx;
        logic [RGB_W-1:0]   rgb;
        rgb = RGB_W'($urandom);
        if ($urandom_range(0, 99) < 12 || written_indices.size() < 4) begin
            idx = INDEX_W'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0) begin
                rgb = $urandom_range(0, 1) ? '1 : '0;
            end
            issue_request(1'b0, idx, rgb, 1'b0, '0);
        end else begin
            // Only read entries that have been written; favor the color key.
            idx = written_indices[$urandom_range(0, written_indices.size() - 1)];
            if (!cfg_shadow.transparent_index[8]
                && palette_written[cfg_shadow.transparent_index[7:0]]
                && $urandom_range(0, 3) == 0) begin
                idx = cfg_shadow.transparent_index[7:0];
            end
            issue_request(1'b1, idx, rgb, 1'b0, '0);
        end
    endtask

    function automatic t_stim_row palette_row(logic [INDEX_W-1:0] idx, logic [RGB_W-1:0] rgb);
        return '{ROW_PALETTE, REG_FRAME_LEFT, 11'd0, idx, rgb, 1'b1, t_fb_write'('0)};
    endfunction

    function automatic t_stim_row pixel_row(logic [INDEX_W-1:0] idx);
        return '{ROW_PIXEL, REG_FRAME_LEFT, 11'd0, idx, 24'd0, 1'b0, t_fb_write'('0)};
    endfunction

    function automatic t_stim_row pixel_row_typed(logic [INDEX_W-1:0] idx, logic we,
                                                  logic [ADDR_W-1:0] addr,
                                                  logic [RGBA_W-1:0] rgba, logic done);
        return '{ROW_PIXEL, REG_FRAME_LEFT, 11'd0, idx, 24'd0, 1'b1,
                 t_fb_write'({we, addr, rgba, done})};
    endfunction

    function automatic t_stim_row config_row(t_cfg_reg sel, logic [CFG_DATA_W-1:0] value);
        return '{ROW_CONFIG, sel, value, 8'd0, 24'd0, 1'b0, t_fb_write'('0)};
    endfunction

    // Receive side: random stalls, compare each result with the oldest expectation.
    initial begin
        int        stall;
        t_fb_write want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = steady_run ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (fb_write_q.size() == 0) begin
                $error("unexpected result: address %0h rgba %0h", o_pixel_address, o_rgba);
                fail_count++;
            end else begin
                want = fb_write_q.pop_front();
                if (o_write_enable !== want.we) begin
                    $error("write_enable: expected %0d, got %0d", want.we, o_write_enable);
                    fail_count++;
                end
                if (o_pixel_address !== want.addr) begin
                    $error("pixel_address: expected %0h, got %0h", want.addr, o_pixel_address);
                    fail_count++;
                end
                if (o_rgba !== want.rgba) begin
                    $error("rgba: expected %0h, got %0h", want.rgba, o_rgba);
                    fail_count++;
                end
                if (o_frame_done !== want.done) begin
                    $error("frame_done: expected %0d, got %0d", want.done, o_frame_done);
                    fail_count++;
                end
            end
        end
    end

    // End the run when neither channel has moved for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_stim_row rows [$];
        t_stim_row row;

        cfg_shadow = '{frame_left: '0, frame_top: '0, frame_width: 11'd1,
                       frame_height: 11'd1, screen_height: 11'd1, pitch_log2: 4'd10,
                       rotate_right: 1'b0, transparent_index: 9'd256};
        row_count    = '0;
        column_count = '0;
        foreach (palette_written[i]) begin
            palette_written[i] = 1'b0;
            palette_shadow[i]  = '0;
        end

        // Reset values: one-pixel rectangle at the origin, no color key.
        rows.push_back(palette_row(8'h00, 24'h000000));
        rows.push_back(palette_row(8'hff, 24'hffffff));
        rows.push_back(palette_row(8'h5a, 24'h123456));
        rows.push_back(palette_row(8'ha5, 24'hedcba9));
        rows.push_back(pixel_row_typed(8'h00, 1'b1, 20'h0, 32'h000000ff, 1'b1));
        rows.push_back(pixel_row_typed(8'hff, 1'b1, 20'h0, 32'hffffffff, 1'b1));
        rows.push_back(pixel_row_typed(8'h5a, 1'b1, 20'h0, 32'h123456ff, 1'b1));
        rows.push_back(config_row(REG_TRANSPARENT_INDEX, 11'h05a));
        rows.push_back(pixel_row_typed(8'h5a, 1'b0, 20'h0, 32'h0, 1'b1));
        rows.push_back(pixel_row_typed(8'ha5, 1'b1, 20'h0, 32'hedcba9ff, 1'b1));
        rows.push_back(config_row(REG_TRANSPARENT_INDEX, 11'd511));
        rows.push_back(pixel_row(8'h5a));
        // Far corner, oversized width, zero height, pitch past the address width
        rows.push_back(config_row(REG_FRAME_LEFT, 11'd1023));
        rows.push_back(config_row(REG_FRAME_TOP, 11'd1023));
        rows.push_back(config_row(REG_FRAME_WIDTH, 11'd2047));
        rows.push_back(config_row(REG_FRAME_HEIGHT, 11'd0));
        rows.push_back(config_row(REG_PITCH_LOG2, 11'd15));
        rows.push_back(pixel_row(8'hff));
        rows.push_back(pixel_row(8'h00));
        rows.push_back(pixel_row(8'ha5));
        // Rotated with a column that goes negative
        rows.push_back(config_row(REG_ROTATE_RIGHT, 11'd1));
        rows.push_back(config_row(REG_SCREEN_HEIGHT, 11'd1));
        rows.push_back(pixel_row(8'h5a));
        rows.push_back(pixel_row(8'hff));
        // Shrink the rectangle under running counters, key on index zero
        rows.push_back(config_row(REG_SCREEN_HEIGHT, 11'd2047));
        rows.push_back(config_row(REG_PITCH_LOG2, 11'd0));
        rows.push_back(config_row(REG_FRAME_WIDTH, 11'd2));
        rows.push_back(config_row(REG_FRAME_HEIGHT, 11'd2));
        rows.push_back(config_row(REG_FRAME_LEFT, 11'd0));
        rows.push_back(config_row(REG_FRAME_TOP, 11'd0));
        rows.push_back(config_row(REG_TRANSPARENT_INDEX, 11'd0));
        rows.push_back(pixel_row(8'h00));
        rows.push_back(pixel_row(8'hff));
        rows.push_back(pixel_row(8'h5a));
        rows.push_back(pixel_row(8'ha5));
        rows.push_back(pixel_row(8'h00));
        rows.push_back(config_row(REG_ROTATE_RIGHT, 11'd0));
        rows.push_back(config_row(REG_PITCH_LOG2, 11'd1));
        rows.push_back(config_row(REG_FRAME_WIDTH, 11'd0));
        rows.push_back(pixel_row(8'hff));
        rows.push_back(pixel_row(8'h5a));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[n]) begin
            row = rows[n];
            case (row.kind)
                ROW_CONFIG: begin
                    wait_idle();
                    write_reg(row.cfg_sel, row.value);
                end
                ROW_PALETTE: issue_request(1'b0, row.index, row.rgb, row.typed, row.result);
                default:     issue_request(1'b1, row.index, row.rgb, row.typed, row.result);
            endcase
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            for (int r = 0; r < 8; r++) begin
                write_reg(t_cfg_reg'(r), random_reg_value(t_cfg_reg'(r)));
            end
            steady_run = (phase % 4 == 3);
            for (int k = 0; k < PHASE_REQUESTS; k++) begin
                issue_random_request();
            end
            steady_run = 1'b0;
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
